### design/knn_pkg.sv
package knn_pkg;

  localparam int FEAT_W   = 16;
  localparam int NUM_FEAT = 4;
  localparam int FI_W     = 2;
  localparam int LABEL_W  = 8;
  localparam int SQ_W     = 32;
  localparam int DIST_W   = 35;
  localparam int DIMS_W   = 3;
  localparam int KCFG_W   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_Q0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Q1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Q2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Q3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_K    = 3'd5;

  localparam logic [DIMS_W-1:0] DIMS_RST = 3'd4;
  localparam logic [KCFG_W-1:0] K_RST    = 4'd3;

  typedef struct packed {
    logic signed [FEAT_W-1:0] sample_feature_0;
    logic signed [FEAT_W-1:0] sample_feature_1;
    logic signed [FEAT_W-1:0] sample_feature_2;
    logic signed [FEAT_W-1:0] sample_feature_3;
    logic [LABEL_W-1:0]       sample_label;
    logic                     last_sample;
  } knn_in_t;

  typedef struct packed {
    logic [LABEL_W-1:0] predicted_label;
    logic               too_few_samples;
  } knn_out_t;

  typedef struct packed {
    logic               valid;
    logic [DIST_W-1:0]  sq_dist;
    logic [LABEL_W-1:0] label;
    logic               last;
  } knn_samp_t;

  typedef struct packed {
    logic upd;
    logic at_last;
  } knn_cell_ctl_t;

endpackage

### design/knn_dist.sv
module knn_dist import knn_pkg::*; (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               accept,
  input  knn_in_t                            in_data,
  input  logic [NUM_FEAT-1:0][FEAT_W-1:0]    query,
  input  logic [DIMS_W-1:0]                  dims_eff,
  output knn_samp_t                          samp,
  output logic                               last_pend
);

  logic [NUM_FEAT-1:0][FEAT_W-1:0] feat;
  logic [NUM_FEAT-1:0][SQ_W-1:0]   sq_nxt;
  logic [NUM_FEAT-1:0][SQ_W-1:0]   sq_r;
  logic                            a_valid_r;
  logic                            a_last_r;
  logic [LABEL_W-1:0]              a_label_r;
  logic [DIST_W-1:0]               sum_nxt;
  knn_samp_t                       b_r;

  assign feat[0] = in_data.sample_feature_0;
  assign feat[1] = in_data.sample_feature_1;
  assign feat[2] = in_data.sample_feature_2;
  assign feat[3] = in_data.sample_feature_3;

  always_comb begin
    logic signed [FEAT_W:0] diff;
    logic [FEAT_W-1:0]      mag;
    for (int d = 0; d < NUM_FEAT; d++) begin
      diff = $signed({query[d][FEAT_W-1], query[d]}) - $signed({feat[d][FEAT_W-1], feat[d]});
      mag  = diff[FEAT_W] ? FEAT_W'(-diff) : diff[FEAT_W-1:0];
      if (DIMS_W'(d) < dims_eff) begin
        sq_nxt[d] = mag * mag;
      end else begin
        sq_nxt[d] = '0;
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int d = 0; d < NUM_FEAT; d++) begin
      sum_nxt = sum_nxt + DIST_W'(sq_r[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_r.valid <= 1'b0;
    end else begin
      a_valid_r <= accept;
      b_r.valid <= a_valid_r;
    end
    sq_r        <= sq_nxt;
    a_label_r   <= in_data.sample_label;
    a_last_r    <= in_data.last_sample;
    b_r.sq_dist <= sum_nxt;
    b_r.label   <= a_label_r;
    b_r.last    <= a_last_r;
  end

  assign samp      = b_r;
  assign last_pend = (a_valid_r && a_last_r) || (b_r.valid && b_r.last);

endmodule

### design/knn_cell.sv
module knn_cell import knn_pkg::*; (
  input  logic               clk,
  input  logic               occ,
  input  knn_cell_ctl_t      ctl,
  input  logic [DIST_W-1:0]  new_dist,
  input  logic [LABEL_W-1:0] new_label,
  input  logic [DIST_W-1:0]  left_dist,
  input  logic [LABEL_W-1:0] left_label,
  input  logic               left_gt,
  output logic               gt,
  output logic [DIST_W-1:0]  dist_r,
  output logic [LABEL_W-1:0] label_r
);

  logic [DIST_W-1:0]  dist_nxt;
  logic [LABEL_W-1:0] label_nxt;

  assign gt = occ && (dist_r > new_dist);

  always_comb begin
    dist_nxt  = dist_r;
    label_nxt = label_r;
    if (ctl.upd) begin
      if (left_gt) begin
        dist_nxt  = left_dist;
        label_nxt = left_label;
      end else if (gt || ctl.at_last) begin
        dist_nxt  = new_dist;
        label_nxt = new_label;
      end
    end
  end

  always_ff @(posedge clk) begin
    dist_r  <= dist_nxt;
    label_r <= label_nxt;
  end

endmodule

### design/knn_chain.sv
module knn_chain import knn_pkg::*; #(
  parameter int MAX_K = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  knn_samp_t                         samp,
  input  logic [$clog2(MAX_K+1)-1:0]        k_eff,
  output logic [MAX_K-1:0][LABEL_W-1:0]     labels,
  output logic                              vote_load,
  output logic [$clog2(MAX_K+1)-1:0]        vote_n,
  output logic                              vote_few
);

  localparam int CNT_W = $clog2(MAX_K + 1);
  localparam int IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;

  logic [CNT_W-1:0]                count_r;
  logic [CNT_W-1:0]                count_nxt;
  logic [CNT_W-1:0]                cnt_e;
  logic [CNT_W-1:0]                last_pos;
  logic [CNT_W-1:0]                n_post;
  logic                            full;
  logic                            ins;
  logic [MAX_K-1:0]                gt_v;
  logic [MAX_K-1:0][DIST_W-1:0]    dist_v;

  assign cnt_e    = (count_r > k_eff) ? k_eff : count_r;
  assign full     = (cnt_e >= k_eff);
  assign last_pos = full ? (k_eff - CNT_W'(1)) : cnt_e;
  assign ins      = samp.valid && (!full || gt_v[last_pos[IDX_W-1:0]]);
  assign n_post   = full ? cnt_e : (cnt_e + CNT_W'(1));

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    knn_cell_ctl_t ctl;
    logic          occ;

    assign occ         = (CNT_W'(i) < cnt_e);
    assign ctl.upd     = ins && (CNT_W'(i) <= last_pos);
    assign ctl.at_last = (CNT_W'(i) == last_pos);

    if (i == 0) begin : g_head
      knn_cell u_cell (
        .clk        (clk),
        .occ        (occ),
        .ctl        (ctl),
        .new_dist   (samp.sq_dist),
        .new_label  (samp.label),
        .left_dist  ('0),
        .left_label ('0),
        .left_gt    (1'b0),
        .gt         (gt_v[i]),
        .dist_r     (dist_v[i]),
        .label_r    (labels[i])
      );
    end else begin : g_body
      knn_cell u_cell (
        .clk        (clk),
        .occ        (occ),
        .ctl        (ctl),
        .new_dist   (samp.sq_dist),
        .new_label  (samp.label),
        .left_dist  (dist_v[i-1]),
        .left_label (labels[i-1]),
        .left_gt    (gt_v[i-1]),
        .gt         (gt_v[i]),
        .dist_r     (dist_v[i]),
        .label_r    (labels[i])
      );
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (samp.valid) begin
      count_nxt = samp.last ? '0 : n_post;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign vote_load = samp.valid && samp.last;
  assign vote_n    = n_post;
  assign vote_few  = (n_post < k_eff);

endmodule

### design/knn_vote.sv
module knn_vote import knn_pkg::*; #(
  parameter int MAX_K = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [MAX_K-1:0][LABEL_W-1:0]     labels,
  input  logic                              load,
  input  logic [$clog2(MAX_K+1)-1:0]        n,
  input  logic                              few,
  input  logic                              out_stall,
  output logic                              out_valid,
  output knn_out_t                          out_data,
  output logic                              busy
);

  localparam int CNT_W = $clog2(MAX_K + 1);
  localparam int IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   bestn_r, bestn_nxt;
  logic [LABEL_W-1:0] best_r, best_nxt;
  logic               few_r, few_nxt;
  logic [LABEL_W-1:0] cur;
  logic [CNT_W-1:0]   hits;
  logic               better;

  assign cur = labels[idx_r];

  always_comb begin
    hits = '0;
    for (int j = 0; j < MAX_K; j++) begin
      if ((CNT_W'(j) < n_r) && (labels[j] == cur)) begin
        hits = hits + CNT_W'(1);
      end
    end
  end

  assign better = (hits > bestn_r) || ((hits == bestn_r) && (cur < best_r));

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    n_nxt     = n_r;
    bestn_nxt = bestn_r;
    best_nxt  = best_r;
    few_nxt   = few_r;
    unique case (state_r)
      ST_IDLE: begin
        if (load) begin
          idx_nxt   = '0;
          n_nxt     = n;
          bestn_nxt = '0;
          best_nxt  = '0;
          few_nxt   = few;
          state_nxt = (n == '0) ? ST_OUT : ST_RUN;
        end
      end
      ST_RUN: begin
        if (better) begin
          bestn_nxt = hits;
          best_nxt  = cur;
        end
        idx_nxt = idx_r + IDX_W'(1);
        if ((CNT_W'(idx_r) + CNT_W'(1)) == n_r) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    idx_r   <= idx_nxt;
    n_r     <= n_nxt;
    bestn_r <= bestn_nxt;
    best_r  <= best_nxt;
    few_r   <= few_nxt;
  end

  assign out_valid                = (state_r == ST_OUT);
  assign out_data.predicted_label = best_r;
  assign out_data.too_few_samples = few_r;
  assign busy                     = (state_r != ST_IDLE);

endmodule

### design/knn_classifier.sv
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   knn_in_t: four features, label, last flag
// out       output     out_valid/out_stall knn_out_t: predicted label, too-few flag
// cfg       input      cfg_valid/cfg_ready cfg_index selects register, cfg_data value
//
// Samples are taken one per cycle while in_stall is low; the squared differences and
// then their sum are registered before the neighbor chain inserts the sample by
// parallel compare-and-shift. A last sample holds in_stall high until its result is
// taken, through any out_stall time; the vote unit scans the list one entry a cycle.
// Reset is synchronous active low; config registers return to their defaults and the
// list is emptied. cfg_ready is always high.
module knn_classifier import knn_pkg::*; #(
  parameter int MAX_K = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  knn_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output knn_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_K + 1);

  logic [NUM_FEAT-1:0][FEAT_W-1:0] query_r, query_nxt;
  logic [DIMS_W-1:0]               dims_r, dims_nxt;
  logic [KCFG_W-1:0]               k_r, k_nxt;
  logic [DIMS_W-1:0]               dims_eff;
  logic [CNT_W-1:0]                k_eff;
  logic                            accept;
  logic                            last_pend;
  knn_samp_t                       samp;
  logic [MAX_K-1:0][LABEL_W-1:0]   labels;
  logic                            vote_load;
  logic [CNT_W-1:0]                vote_n;
  logic                            vote_few;
  logic                            vote_busy;

  assign cfg_ready = 1'b1;

  always_comb begin
    query_nxt = query_r;
    dims_nxt  = dims_r;
    k_nxt     = k_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index) inside
        CFG_Q0, CFG_Q1, CFG_Q2, CFG_Q3: query_nxt[cfg_index[FI_W-1:0]] = cfg_data;
        CFG_DIMS: dims_nxt = cfg_data[DIMS_W-1:0];
        CFG_K:    k_nxt    = cfg_data[KCFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_r <= '0;
      dims_r  <= DIMS_RST;
      k_r     <= K_RST;
    end else begin
      query_r <= query_nxt;
      dims_r  <= dims_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    if (dims_r == '0) begin
      dims_eff = DIMS_W'(1);
    end else if (int'(dims_r) > NUM_FEAT) begin
      dims_eff = DIMS_W'(NUM_FEAT);
    end else begin
      dims_eff = dims_r;
    end
  end

  always_comb begin
    if (k_r == '0) begin
      k_eff = CNT_W'(1);
    end else if (int'(k_r) > MAX_K) begin
      k_eff = CNT_W'(MAX_K);
    end else begin
      k_eff = CNT_W'(k_r);
    end
  end

  assign in_stall = vote_busy || last_pend;
  assign accept   = in_valid && !in_stall;

  knn_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .query     (query_r),
    .dims_eff  (dims_eff),
    .samp      (samp),
    .last_pend (last_pend)
  );

  knn_chain #(.MAX_K(MAX_K)) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .samp      (samp),
    .k_eff     (k_eff),
    .labels    (labels),
    .vote_load (vote_load),
    .vote_n    (vote_n),
    .vote_few  (vote_few)
  );

  knn_vote #(.MAX_K(MAX_K)) u_vote (
    .clk       (clk),
    .rst_n     (rst_n),
    .labels    (labels),
    .load      (vote_load),
    .n         (vote_n),
    .few       (vote_few),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .busy      (vote_busy)
  );

endmodule

### design/knn_checker.sv
module knn_checker import knn_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input knn_in_t              in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input knn_out_t             out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result request changed while stalled");

  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last_sample |=> in_stall)
    else $error("input open right after a last sample");

  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while a result is pending");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("result repeated");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind knn_classifier knn_checker u_knn_checker (.*);

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import knn_pkg::*;

  localparam int LIMIT        = 300000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 900;

  class knn_scoreboard;
    logic signed [FEAT_W-1:0] query_pt[NUM_FEAT] = '{default: '0};
    logic [DIMS_W-1:0]        dims_reg = DIMS_RST;
    logic [KCFG_W-1:0]        k_reg = K_RST;
    logic [DIST_W-1:0]        near_dist[8];
    logic [LABEL_W-1:0]       near_label[8];
    int unsigned              kept = 0;
    knn_out_t                 expected_votes[$];
    int                       mismatches = 0;
    int                       results_seen = 0;
    int                       short_votes = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] v);
      case (idx)
        CFG_Q0:   query_pt[0] = v;
        CFG_Q1:   query_pt[1] = v;
        CFG_Q2:   query_pt[2] = v;
        CFG_Q3:   query_pt[3] = v;
        CFG_DIMS: dims_reg = v[DIMS_W-1:0];
        CFG_K:    k_reg = v[KCFG_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_k();
      if (k_reg == 0) return 1;
      if (k_reg > 8) return 8;
      return k_reg;
    endfunction

    function int unsigned eff_dims();
      if (dims_reg == 0) return 1;
      if (dims_reg > NUM_FEAT) return NUM_FEAT;
      return dims_reg;
    endfunction

    function logic [DIST_W-1:0] dist_to_query(knn_in_t r);
      logic signed [FEAT_W-1:0] f[NUM_FEAT];
      longint acc, diff;
      int unsigned d, nd;
      f[0] = r.sample_feature_0;
      f[1] = r.sample_feature_1;
      f[2] = r.sample_feature_2;
      f[3] = r.sample_feature_3;
      acc = 0;
      nd = eff_dims();
      for (d = 0; d < nd; d++) begin
        diff = longint'($signed(query_pt[d])) - longint'($signed(f[d]));
        acc += diff * diff;
      end
      return acc[DIST_W-1:0];
    endfunction

    // sorted insert; ties go behind existing entries, full list needs strictly nearer
    function void insert_neighbor(logic [DIST_W-1:0] d, logic [LABEL_W-1:0] lab,
                                  int unsigned k);
      int unsigned pos, i, tail;
      pos = 0;
      if (kept >= k) begin
        if (!(d < near_dist[k-1])) return;
        tail = k - 1;
      end else begin
        tail = kept;
        kept++;
      end
      while (pos < tail && near_dist[pos] <= d) pos++;
      for (i = tail; i > pos; i--) begin
        near_dist[i]  = near_dist[i-1];
        near_label[i] = near_label[i-1];
      end
      near_dist[pos]  = d;
      near_label[pos] = lab;
    endfunction

    function logic [LABEL_W-1:0] majority_label();
      int unsigned i, j, n, best_n;
      logic [LABEL_W-1:0] best;
      best_n = 0;
      best = '0;
      for (i = 0; i < kept; i++) begin
        n = 0;
        for (j = 0; j < kept; j++)
          if (near_label[j] == near_label[i]) n++;
        if (n > best_n || (n == best_n && near_label[i] < best)) begin
          best_n = n;
          best = near_label[i];
        end
      end
      return best;
    endfunction

    function void note_request(knn_in_t r);
      knn_out_t verdict;
      int unsigned k;
      k = eff_k();
      if (kept > k) kept = k;
      insert_neighbor(dist_to_query(r), r.sample_label, k);
      if (r.last_sample) begin
        verdict.predicted_label = majority_label();
        verdict.too_few_samples = (kept < k);
        if (kept < k) short_votes++;
        expected_votes.push_back(verdict);
        kept = 0;
      end
    endfunction

    task flag(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(knn_out_t got);
      knn_out_t want;
      results_seen++;
      if (expected_votes.size() == 0) begin
        flag($sformatf("unexpected result label=%0d short=%0b",
                       got.predicted_label, got.too_few_samples));
        return;
      end
      want = expected_votes.pop_front();
      if (got.predicted_label !== want.predicted_label)
        flag($sformatf("predicted_label got %0d want %0d",
                       got.predicted_label, want.predicted_label));
      if (got.too_few_samples !== want.too_few_samples)
        flag($sformatf("too_few_samples got %0b want %0b",
                       got.too_few_samples, want.too_few_samples));
    endtask

    function int pending();
      return expected_votes.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  knn_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  knn_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_Q0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  knn_scoreboard sb = new;

  logic [CFG_IDX_W-1:0]     idx_of[6] = '{CFG_Q0, CFG_Q1, CFG_Q2, CFG_Q3, CFG_DIMS, CFG_K};
  logic signed [FEAT_W-1:0] cur_query[NUM_FEAT] = '{default: '0};
  int                       cur_k = 3;
  int                       items_sent = 0;
  int                       cfg_writes = 0;
  int                       burst_left = 4;
  bit                       sending = 1'b0;
  int                       cycles = 0;
  int                       stall_mode = 0;
  int                       stall_hold = 0;

  knn_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_hold = $urandom_range(50, 300);
    end else begin
      stall_hold--;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 99) < 40);
      default: out_stall <= ((stall_hold % 5) < 2);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_request(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  function automatic knn_in_t mk(int f0, int f1, int f2, int f3, int lab, bit lst);
    knn_in_t r;
    r.sample_feature_0 = 16'(f0);
    r.sample_feature_1 = 16'(f1);
    r.sample_feature_2 = 16'(f2);
    r.sample_feature_3 = 16'(f3);
    r.sample_label     = 8'(lab);
    r.last_sample      = lst;
    return r;
  endfunction

  function automatic logic signed [FEAT_W-1:0] near(logic signed [FEAT_W-1:0] c, int spread);
    int v;
    v = int'($signed(c)) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic knn_in_t random_sample(bit lst);
    knn_in_t r;
    logic signed [FEAT_W-1:0] f[NUM_FEAT];
    int i, m, spread;
    m = $urandom_range(0, 19);
    spread = $urandom_range(0, 1) ? 3 : 40;
    for (i = 0; i < NUM_FEAT; i++) begin
      if (m < 15) f[i] = near(cur_query[i], spread);
      else if (m < 19) f[i] = 16'($urandom);
      else f[i] = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    end
    r.sample_feature_0 = f[0];
    r.sample_feature_1 = f[1];
    r.sample_feature_2 = f[2];
    r.sample_feature_3 = f[3];
    r.sample_label = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    r.last_sample = lst;
    return r;
  endfunction

  task automatic send_item(input knn_in_t r);
    int gap;
    in_valid <= 1'b1;
    in_data  <= r;
    sending = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        sending = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop the stream, let outstanding votes land and the pipeline empty
  task automatic settle();
    if (sending) begin
      in_valid <= 1'b0;
      sending = 1'b0;
    end
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(int q0, int q1, int q2, int q3, int dims, int k,
                              bit [5:0] mask);
    logic [CFG_DAT_W-1:0] vals[6];
    int i;
    bit any;
    vals[0] = 16'(q0);
    vals[1] = 16'(q1);
    vals[2] = 16'(q2);
    vals[3] = 16'(q3);
    vals[4] = {13'($urandom), 3'(dims)};
    vals[5] = {12'($urandom), 4'(k)};
    any = 1'b0;
    for (i = 0; i < 6; i++) begin
      if (mask[i]) begin
        cfg_valid <= 1'b1;
        cfg_index <= idx_of[i];
        cfg_data  <= vals[i];
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        any = 1'b1;
        cfg_writes++;
        if (i < NUM_FEAT) cur_query[i] = vals[i];
        if (i == 5) cur_k = k & 15;
      end
    end
    if (any) cfg_valid <= 1'b0;
  endtask

  function automatic int random_coord();
    int m;
    m = $urandom_range(0, 3);
    if (m < 2) return int'($signed(16'($urandom)));
    if (m == 2) return int'($urandom_range(0, 200)) - 100;
    return $urandom_range(0, 1) ? 32767 : -32768;
  endfunction

  task automatic directed_part();
    // reset defaults: origin query, four dims, k of three, all labels differ
    send_item(mk(-32768, -32768, -32768, -32768, 255, 0));
    send_item(mk(32767, 32767, 32767, 32767, 0, 0));
    send_item(mk(0, 0, 0, 0, 7, 1));
    settle();
    // largest possible distance, list left short
    apply_config(32767, -32768, 32767, -32768, 4, 8, 6'h3f);
    send_item(mk(-32768, 32767, -32768, 32767, 1, 1));
    settle();
    // one dim, ties at equal distance, full list rejects an equal one
    apply_config(100, 0, 0, 0, 1, 4, 6'h3f);
    send_item(mk(90, -32768, 32767, -32768, 5, 0));
    send_item(mk(110, 32767, -32768, 32767, 3, 0));
    send_item(mk(100, 0, 0, 0, 5, 0));
    send_item(mk(110, 5, 6, 7, 3, 0));
    send_item(mk(90, -1, -1, -1, 3, 0));
    send_item(mk(105, 1, 1, 1, 9, 1));
    settle();
    // zero dims and zero k act as one
    apply_config(0, 0, 0, 0, 0, 0, 6'b110000);
    send_item(mk(120, 0, 0, 0, 2, 0));
    send_item(mk(101, 0, 0, 0, 4, 1));
    settle();
    // dims and k beyond range saturate
    apply_config(0, 0, 0, 0, 7, 15, 6'b110000);
    send_item(mk(100, 3, 3, 3, 6, 0));
    send_item(mk(-100, 3, 3, 3, 6, 1));
    settle();
    // k lowered with a list already built
    apply_config(0, 0, 0, 0, 4, 6, 6'b110000);
    send_item(mk(100, 10, 10, 10, 1, 0));
    send_item(mk(100, 20, 10, 10, 2, 0));
    send_item(mk(100, 30, 10, 10, 2, 0));
    send_item(mk(100, 40, 10, 10, 1, 0));
    send_item(mk(100, 50, 10, 10, 3, 0));
    settle();
    apply_config(0, 0, 0, 0, 4, 2, 6'b100000);
    send_item(mk(100, 25, 10, 10, 3, 1));
    settle();
  endtask

  initial begin
    int len, i, dims, k;
    bit broken;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_part();
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        settle();
        dims = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(0, 7);
        k = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(0, 15);
        apply_config(random_coord(), random_coord(), random_coord(), random_coord(),
                     dims, k, 6'($urandom_range(1, 63)));
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 10);
      broken = ($urandom_range(0, 9) == 0);
      for (i = 0; i < len; i++)
        send_item(random_sample(i == len - 1 && !broken));
      if (broken && $urandom_range(0, 1)) begin
        settle();
        apply_config(0, 0, 0, 0, 0, $urandom_range(0, cur_k), 6'b100000);
      end
    end
    settle();
    $display("Checked %0d votes from %0d random samples plus directed cases, %0d reg writes",
             sb.results_seen, items_sent, cfg_writes);
    $display("%0d votes came from lists shorter than k", sb.short_votes);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
